@@ src/stt_pkg.sv @@
// ----------------------------------------------------------------------------
// stt_pkg: shared types and constants of the source text tokenizer
// Token kinds, byte codes, scan modes, token records and keyword lookup.
// ----------------------------------------------------------------------------
package stt_pkg;

   localparam int MAX_FRAC = 9;
   localparam int POS_W    = 16;
   localparam int Q_DEPTH  = 4;
   localparam int Q_AW     = 2;

   typedef enum logic [3:0] {
      M_IDLE, M_OP, M_COMMENT, M_CHAR_OPEN, M_CHAR_BODY,
      M_STRING, M_INT, M_REAL, M_WORD
   } mode_type;

   // token kinds
   localparam logic [5:0] K_END = 6'd0,   K_ANDAND = 6'd1,  K_AND = 6'd2;
   localparam logic [5:0] K_OROR = 6'd3,  K_OR = 6'd4,      K_EQEQ = 6'd5;
   localparam logic [5:0] K_ASSIGN = 6'd6, K_NE = 6'd7,     K_NOT = 6'd8;
   localparam logic [5:0] K_LE = 6'd9,    K_LT = 6'd10,     K_GE = 6'd11;
   localparam logic [5:0] K_GT = 6'd12,   K_PLUS = 6'd13,   K_MINUS = 6'd14;
   localparam logic [5:0] K_STAR = 6'd15, K_SLASH = 6'd16,  K_LPAREN = 6'd17;
   localparam logic [5:0] K_RPAREN = 6'd18, K_LBRACK = 6'd19, K_RBRACK = 6'd20;
   localparam logic [5:0] K_LBRACE = 6'd21, K_RBRACE = 6'd22, K_CHARLIT = 6'd23;
   localparam logic [5:0] K_STRING = 6'd24, K_INTLIT = 6'd25, K_REALLIT = 6'd26;
   localparam logic [5:0] K_IDENT = 6'd27, K_IF = 6'd28,    K_ELSE = 6'd29;
   localparam logic [5:0] K_WHILE = 6'd30, K_DO = 6'd31,    K_BREAK = 6'd32;
   localparam logic [5:0] K_FN = 6'd33,   K_DATATYPE = 6'd34, K_TRUE = 6'd35;
   localparam logic [5:0] K_FALSE = 6'd36, K_SEMI = 6'd37,  K_COMMA = 6'd38;
   localparam logic [5:0] K_COLON = 6'd39, K_UNKNOWN = 6'd40;

   // datatype codes
   localparam logic [1:0] DT_INT = 2'd0, DT_FLOAT = 2'd1, DT_CHAR = 2'd2, DT_BOOL = 2'd3;

   // byte codes
   localparam logic [7:0] B_TAB = 8'h09, B_LF = 8'h0A, B_SPACE = 8'h20;
   localparam logic [7:0] B_BANG = 8'h21, B_DQUOTE = 8'h22, B_AMP = 8'h26;
   localparam logic [7:0] B_SQUOTE = 8'h27, B_LPAREN = 8'h28, B_RPAREN = 8'h29;
   localparam logic [7:0] B_STAR = 8'h2A, B_PLUS = 8'h2B, B_COMMA = 8'h2C;
   localparam logic [7:0] B_MINUS = 8'h2D, B_DOT = 8'h2E, B_SLASH = 8'h2F;
   localparam logic [7:0] B_ZERO = 8'h30, B_NINE = 8'h39, B_COLON = 8'h3A;
   localparam logic [7:0] B_SEMI = 8'h3B, B_LT = 8'h3C, B_EQ = 8'h3D;
   localparam logic [7:0] B_GT = 8'h3E, B_UA = 8'h41, B_UZ = 8'h5A;
   localparam logic [7:0] B_LBRACK = 8'h5B, B_RBRACK = 8'h5D, B_UNDER = 8'h5F;
   localparam logic [7:0] B_LA = 8'h61, B_LZ = 8'h7A, B_LBRACE = 8'h7B;
   localparam logic [7:0] B_BAR = 8'h7C, B_RBRACE = 8'h7D;

   // keywords, first byte in the lowest bits
   localparam logic [39:0] W_IF    = 40'h0000006669;
   localparam logic [39:0] W_ELSE  = 40'h0065736c65;
   localparam logic [39:0] W_WHILE = 40'h656c696877;
   localparam logic [39:0] W_DO    = 40'h0000006f64;
   localparam logic [39:0] W_BREAK = 40'h6b61657262;
   localparam logic [39:0] W_FN    = 40'h0000006e66;
   localparam logic [39:0] W_INT   = 40'h0000746e69;
   localparam logic [39:0] W_FLOAT = 40'h74616f6c66;
   localparam logic [39:0] W_CHAR  = 40'h0072616863;
   localparam logic [39:0] W_BOOL  = 40'h006c6f6f62;
   localparam logic [39:0] W_TRUE  = 40'h0065757274;
   localparam logic [39:0] W_FALSE = 40'h65736c6166;

   typedef struct packed {
      logic [5:0]       kind;
      logic [31:0]      ival;
      logic [29:0]      fval;
      logic [3:0]       fdig;
      logic [15:0]      len;
      logic [POS_W-1:0] sline;
      logic [POS_W-1:0] scol;
   } token_type;

   // one to two tokens caused by one byte
   typedef struct packed {
      logic      two;
      token_type t0;
      token_type t1;
   } pair_type;

   function automatic token_type mk_tok(input logic [5:0] kind, input logic [31:0] ival,
                                        input logic [15:0] len, input logic [POS_W-1:0] sl,
                                        input logic [POS_W-1:0] sc);
      token_type t;
      t       = '0;
      t.kind  = kind;
      t.ival  = ival;
      t.len   = len;
      t.sline = sl;
      t.scol  = sc;
      return t;
   endfunction

   function automatic logic [5:0] single_op_kind(input logic [7:0] p);
      unique case (p)
         B_AMP:   return K_AND;
         B_BAR:   return K_OR;
         B_EQ:    return K_ASSIGN;
         B_BANG:  return K_NOT;
         B_LT:    return K_LT;
         B_GT:    return K_GT;
         default: return K_SLASH;
      endcase
   endfunction

   // zero means no pairing
   function automatic logic [5:0] pair_kind(input logic [7:0] p, input logic [7:0] c);
      priority if (p == B_AMP && c == B_AMP) return K_ANDAND;
      else if (p == B_BAR && c == B_BAR)     return K_OROR;
      else if (p == B_EQ && c == B_EQ)       return K_EQEQ;
      else if (p == B_BANG && c == B_EQ)     return K_NE;
      else if (p == B_LT && c == B_EQ)       return K_LE;
      else if (p == B_GT && c == B_EQ)       return K_GE;
      else                                   return K_END;
   endfunction

   // one-byte tokens; zero means none
   function automatic logic [5:0] punct_kind(input logic [7:0] c);
      unique case (c)
         B_PLUS:   return K_PLUS;
         B_MINUS:  return K_MINUS;
         B_STAR:   return K_STAR;
         B_LPAREN: return K_LPAREN;
         B_RPAREN: return K_RPAREN;
         B_LBRACK: return K_LBRACK;
         B_RBRACK: return K_RBRACK;
         B_LBRACE: return K_LBRACE;
         B_RBRACE: return K_RBRACE;
         B_SEMI:   return K_SEMI;
         B_COMMA:  return K_COMMA;
         B_COLON:  return K_COLON;
         default:  return K_END;
      endcase
   endfunction

   // {kind, datatype code}; bytes past the length are zero in the prefix
   function automatic logic [7:0] word_lookup(input logic [39:0] pre, input logic [15:0] len);
      priority if (len == 16'd2 && pre == W_IF)    return {K_IF, 2'd0};
      else if (len == 16'd4 && pre == W_ELSE)      return {K_ELSE, 2'd0};
      else if (len == 16'd5 && pre == W_WHILE)     return {K_WHILE, 2'd0};
      else if (len == 16'd2 && pre == W_DO)        return {K_DO, 2'd0};
      else if (len == 16'd5 && pre == W_BREAK)     return {K_BREAK, 2'd0};
      else if (len == 16'd2 && pre == W_FN)        return {K_FN, 2'd0};
      else if (len == 16'd3 && pre == W_INT)       return {K_DATATYPE, DT_INT};
      else if (len == 16'd5 && pre == W_FLOAT)     return {K_DATATYPE, DT_FLOAT};
      else if (len == 16'd4 && pre == W_CHAR)      return {K_DATATYPE, DT_CHAR};
      else if (len == 16'd4 && pre == W_BOOL)      return {K_DATATYPE, DT_BOOL};
      else if (len == 16'd4 && pre == W_TRUE)      return {K_TRUE, 2'd0};
      else if (len == 16'd5 && pre == W_FALSE)     return {K_FALSE, 2'd0};
      else                                         return {K_IDENT, 2'd0};
   endfunction

endpackage

@@ src/stt_front.sv @@
// ----------------------------------------------------------------------------
// stt_front: byte scanner
// Classifies each accepted byte, updates the scan state and forms the
// tokens (up to two) that the byte completes.
// ----------------------------------------------------------------------------
module stt_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              take,
   input  logic [7:0]        ch,
   input  logic              endm,
   output logic              push,
   output stt_pkg::pair_type pair
);

   stt_pkg::mode_type mode_ff, mode_in;
   logic [7:0]  pend_ff, pend_in;
   logic [31:0] iacc_ff, iacc_in;
   logic [29:0] facc_ff, facc_in;
   logic [3:0]  fcnt_ff, fcnt_in;
   logic [39:0] wpre_ff, wpre_in;
   logic [15:0] wlen_ff, wlen_in;
   logic [7:0]  cbyte_ff, cbyte_in;
   logic [stt_pkg::POS_W-1:0] line_ff, line_in, col_ff, col_in;
   logic [stt_pkg::POS_W-1:0] tline_ff, tline_in, tcol_ff, tcol_in;
   logic        done_ff, done_in;

   logic [stt_pkg::POS_W-1:0] line_new, col_new;
   logic        is_end, is_digit, is_alpha, redo;
   logic        flush_v, v0, v1;
   stt_pkg::token_type flush_t, t0, t1;
   logic [5:0]  pk, sk;
   logic [7:0]  wl;
   logic [31:0] digit;

   assign is_digit = (ch >= stt_pkg::B_ZERO) && (ch <= stt_pkg::B_NINE);
   assign is_alpha = ((ch >= stt_pkg::B_LA) && (ch <= stt_pkg::B_LZ)) ||
                     ((ch >= stt_pkg::B_UA) && (ch <= stt_pkg::B_UZ)) ||
                     (ch == stt_pkg::B_UNDER);
   assign is_end   = endm || (ch == 8'd0) || ch[7];
   assign digit    = {28'd0, ch[3:0]};
   assign pk       = stt_pkg::pair_kind(pend_ff, ch);
   assign sk       = stt_pkg::punct_kind(ch);
   assign wl       = stt_pkg::word_lookup(wpre_ff, wlen_ff);

   // counters after this byte
   always_comb begin
      line_new = line_ff;
      col_new  = col_ff + 1'b1;
      if (ch == stt_pkg::B_LF) begin
         line_new = line_ff + 1'b1;
         col_new  = '0;
      end
   end

   // token left pending by the current mode
   always_comb begin
      flush_v = 1'b0;
      flush_t = '0;
      unique case (mode_ff)
         stt_pkg::M_OP: begin
            flush_v = 1'b1;
            flush_t = stt_pkg::mk_tok(stt_pkg::single_op_kind(pend_ff), 32'd0, 16'd0,
                                      tline_ff, tcol_ff);
         end
         stt_pkg::M_INT: begin
            flush_v = 1'b1;
            flush_t = stt_pkg::mk_tok(stt_pkg::K_INTLIT, iacc_ff, 16'd0, tline_ff, tcol_ff);
         end
         stt_pkg::M_REAL: begin
            flush_v = 1'b1;
            flush_t = stt_pkg::mk_tok(stt_pkg::K_REALLIT, iacc_ff, 16'd0, tline_ff, tcol_ff);
            flush_t.fval = facc_ff;
            flush_t.fdig = fcnt_ff;
         end
         stt_pkg::M_WORD: begin
            flush_v = 1'b1;
            flush_t = stt_pkg::mk_tok(wl[7:2], {30'd0, wl[1:0]}, wlen_ff, tline_ff, tcol_ff);
         end
         default: begin
            flush_v = 1'b0;
         end
      endcase
   end

   // scan step
   always_comb begin
      mode_in  = mode_ff;
      pend_in  = pend_ff;
      iacc_in  = iacc_ff;
      facc_in  = facc_ff;
      fcnt_in  = fcnt_ff;
      wpre_in  = wpre_ff;
      wlen_in  = wlen_ff;
      cbyte_in = cbyte_ff;
      line_in  = line_ff;
      col_in   = col_ff;
      tline_in = tline_ff;
      tcol_in  = tcol_ff;
      done_in  = done_ff;
      v0 = 1'b0;
      t0 = '0;
      v1 = 1'b0;
      t1 = '0;
      redo = 1'b0;
      if (take && !done_ff) begin
         if (!endm) begin
            line_in = line_new;
            col_in  = col_new;
         end
         if (is_end) begin
            v0 = flush_v;
            t0 = flush_t;
            v1 = 1'b1;
            t1 = stt_pkg::mk_tok(stt_pkg::K_END, 32'd0, 16'd0,
                                 endm ? line_ff : line_new, endm ? col_ff : col_new);
            mode_in = stt_pkg::M_IDLE;
            done_in = 1'b1;
         end else begin
            unique case (mode_ff)
               stt_pkg::M_OP: begin
                  if (pk != stt_pkg::K_END) begin
                     v0 = 1'b1;
                     t0 = stt_pkg::mk_tok(pk, 32'd0, 16'd0, tline_ff, tcol_ff);
                     mode_in = stt_pkg::M_IDLE;
                  end else if (pend_ff == stt_pkg::B_SLASH && ch == stt_pkg::B_SLASH) begin
                     mode_in = stt_pkg::M_COMMENT;
                  end else begin
                     v0 = flush_v;
                     t0 = flush_t;
                     redo = 1'b1;
                  end
               end
               stt_pkg::M_COMMENT: begin
                  if (ch == stt_pkg::B_LF) mode_in = stt_pkg::M_IDLE;
               end
               stt_pkg::M_CHAR_OPEN: begin
                  cbyte_in = ch;
                  mode_in  = stt_pkg::M_CHAR_BODY;
               end
               stt_pkg::M_CHAR_BODY: begin
                  mode_in = stt_pkg::M_IDLE;
                  if (ch == stt_pkg::B_SQUOTE) begin
                     v0 = 1'b1;
                     t0 = stt_pkg::mk_tok(stt_pkg::K_CHARLIT, {24'd0, cbyte_ff}, 16'd0,
                                          tline_ff, tcol_ff);
                  end else begin
                     redo = 1'b1;
                  end
               end
               stt_pkg::M_STRING: begin
                  if (ch == stt_pkg::B_DQUOTE) begin
                     v0 = 1'b1;
                     t0 = stt_pkg::mk_tok(stt_pkg::K_STRING, 32'd0, wlen_ff, tline_ff, tcol_ff);
                     mode_in = stt_pkg::M_IDLE;
                  end else if (ch == stt_pkg::B_LF) begin
                     mode_in = stt_pkg::M_IDLE;
                  end else if (wlen_ff != 16'hFFFF) begin
                     wlen_in = wlen_ff + 16'd1;
                  end
               end
               stt_pkg::M_INT: begin
                  if (is_digit) begin
                     iacc_in = (iacc_ff << 3) + (iacc_ff << 1) + digit;
                  end else if (ch == stt_pkg::B_DOT) begin
                     mode_in = stt_pkg::M_REAL;
                     facc_in = '0;
                     fcnt_in = '0;
                  end else begin
                     v0 = flush_v;
                     t0 = flush_t;
                     redo = 1'b1;
                  end
               end
               stt_pkg::M_REAL: begin
                  if (is_digit) begin
                     if (fcnt_ff < 4'(stt_pkg::MAX_FRAC)) begin
                        facc_in = (facc_ff << 3) + (facc_ff << 1) + digit[29:0];
                        fcnt_in = fcnt_ff + 4'd1;
                     end
                  end else begin
                     v0 = flush_v;
                     t0 = flush_t;
                     redo = 1'b1;
                  end
               end
               stt_pkg::M_WORD: begin
                  if (is_alpha || is_digit) begin
                     if (wlen_ff < 16'd5)
                        wpre_in = wpre_ff | ({32'd0, ch} << {wlen_ff[2:0], 3'b000});
                     if (wlen_ff != 16'hFFFF) wlen_in = wlen_ff + 16'd1;
                  end else begin
                     v0 = flush_v;
                     t0 = flush_t;
                     redo = 1'b1;
                  end
               end
               default: begin
                  redo = 1'b1;
               end
            endcase

            // start of a new token from idle
            if (redo) begin
               mode_in = stt_pkg::M_IDLE;
               if (ch != stt_pkg::B_SPACE && ch != stt_pkg::B_TAB && ch != stt_pkg::B_LF) begin
                  tline_in = line_new;
                  tcol_in  = col_new;
                  priority if (ch == stt_pkg::B_AMP || ch == stt_pkg::B_BAR ||
                               ch == stt_pkg::B_EQ || ch == stt_pkg::B_BANG ||
                               ch == stt_pkg::B_LT || ch == stt_pkg::B_GT ||
                               ch == stt_pkg::B_SLASH) begin
                     mode_in = stt_pkg::M_OP;
                     pend_in = ch;
                  end else if (sk != stt_pkg::K_END) begin
                     v1 = 1'b1;
                     t1 = stt_pkg::mk_tok(sk, 32'd0, 16'd0, line_new, col_new);
                  end else if (ch == stt_pkg::B_SQUOTE) begin
                     mode_in = stt_pkg::M_CHAR_OPEN;
                  end else if (ch == stt_pkg::B_DQUOTE) begin
                     mode_in = stt_pkg::M_STRING;
                     wlen_in = '0;
                  end else if (is_digit) begin
                     mode_in = stt_pkg::M_INT;
                     iacc_in = digit;
                     facc_in = '0;
                     fcnt_in = '0;
                  end else if (is_alpha) begin
                     mode_in = stt_pkg::M_WORD;
                     wpre_in = {32'd0, ch};
                     wlen_in = 16'd1;
                  end else begin
                     v1 = 1'b1;
                     t1 = stt_pkg::mk_tok(stt_pkg::K_UNKNOWN, 32'd0, 16'd0, line_new, col_new);
                  end
               end
            end
         end
      end
   end

   // pack the tokens, first one into slot zero
   always_comb begin
      push     = v0 || v1;
      pair.two = v0 && v1;
      pair.t0  = v0 ? t0 : t1;
      pair.t1  = t1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= stt_pkg::M_IDLE;
         done_ff  <= 1'b0;
         line_ff  <= '0;
         col_ff   <= '0;
         tline_ff <= '0;
         tcol_ff  <= '0;
      end else begin
         mode_ff  <= mode_in;
         done_ff  <= done_in;
         line_ff  <= line_in;
         col_ff   <= col_in;
         tline_ff <= tline_in;
         tcol_ff  <= tcol_in;
      end
   end

   always_ff @(posedge clock) begin
      pend_ff  <= pend_in;
      iacc_ff  <= iacc_in;
      facc_ff  <= facc_in;
      fcnt_ff  <= fcnt_in;
      wpre_ff  <= wpre_in;
      wlen_ff  <= wlen_in;
      cbyte_ff <= cbyte_in;
   end

endmodule

@@ src/stt_queue.sv @@
// ----------------------------------------------------------------------------
// stt_queue: token pair queue
// Short register queue between scanner and output stage.
// ----------------------------------------------------------------------------
module stt_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  stt_pkg::pair_type wr_pair,
   input  logic              pop,
   output logic              not_empty,
   output logic              full,
   output stt_pkg::pair_type head
);

   stt_pkg::pair_type mem_ff [stt_pkg::Q_DEPTH];
   logic [stt_pkg::Q_AW-1:0] wr_ff, wr_in, rd_ff, rd_in;
   logic [stt_pkg::Q_AW:0]   cnt_ff, cnt_in;

   assign not_empty = (cnt_ff != '0);
   assign full      = (cnt_ff == (stt_pkg::Q_AW+1)'(stt_pkg::Q_DEPTH));
   assign head      = mem_ff[rd_ff];

   // pointer and fill count update
   always_comb begin
      wr_in  = wr_ff;
      rd_in  = rd_ff;
      cnt_in = cnt_ff;
      if (push) wr_in = wr_ff + 1'b1;
      if (pop)  rd_in = rd_ff + 1'b1;
      if (push && !pop) cnt_in = cnt_ff + 1'b1;
      else if (pop && !push) cnt_in = cnt_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) mem_ff[wr_ff] <= wr_pair;
   end

endmodule

@@ src/stt_back.sv @@
// ----------------------------------------------------------------------------
// stt_back: output stage
// Splits each queued pair into single token transfers in an output register.
// ----------------------------------------------------------------------------
module stt_back (
   input  logic               clock,
   input  logic               reset,
   input  logic               q_valid,
   input  stt_pkg::pair_type  head,
   output logic               pop,
   output logic               out_valid,
   output stt_pkg::token_type out_tok,
   output logic               out_last,
   input  logic               out_ready
);

   logic               ov_ff, ov_in, sel_ff, sel_in, last_ff, last_in;
   stt_pkg::token_type tok_ff, tok_in;
   logic               load;

   assign load      = !ov_ff || out_ready;
   assign out_valid = ov_ff;
   assign out_tok   = tok_ff;
   assign out_last  = last_ff;

   // take the next token of the head pair
   always_comb begin
      ov_in   = ov_ff;
      sel_in  = sel_ff;
      last_in = last_ff;
      tok_in  = tok_ff;
      pop     = 1'b0;
      if (load) begin
         ov_in = q_valid;
         if (q_valid) begin
            tok_in  = sel_ff ? head.t1 : head.t0;
            last_in = !head.two || sel_ff;
            pop     = last_in;
            sel_in  = !last_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ov_ff  <= 1'b0;
         sel_ff <= 1'b0;
      end else begin
         ov_ff  <= ov_in;
         sel_ff <= sel_in;
      end
   end

   always_ff @(posedge clock) begin
      tok_ff  <= tok_in;
      last_ff <= last_in;
   end

endmodule

@@ src/source_text_tokenizer.sv @@
// ----------------------------------------------------------------------------
// source_text_tokenizer: streaming lexer for a small C-like language
// Source bytes in, tokens out, one token per output transfer.
// ----------------------------------------------------------------------------
// Usage:
//   req_* carries one source byte per transfer; req_tuser set marks end of
//   input. A NUL byte, a byte of 128 or more, or the end mark flushes the
//   pending token and gives the end token; later bytes are taken and dropped.
//   rsp_* carries tokens; rsp_tlast is set on the final token of a byte.
//   Throughput: one byte per cycle while the queue has room; each byte gives
//   zero, one or two tokens, and the output register sends one per cycle
//   while rsp_tready is high. A token passes from the scanner through the
//   queue and the output register to rsp. req_tready drops only when the
//   four-entry pair queue is full, so a stalled receiver backs up through
//   the queue to the source.
//   Reset clears the scan state, counters and queue; no clearing pass.
// ----------------------------------------------------------------------------
module source_text_tokenizer (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_tvalid,
   output logic          req_tready,
   input  logic [7:0]    req_tdata,  // ch
   input  logic          req_tuser,  // end_marker
   output logic          rsp_tvalid,
   input  logic          rsp_tready,
   // kind[5:0], int_value[37:6], fraction_value[67:38], fraction_digits[71:68],
   // lexeme_length[87:72], start_line[103:88], start_column[119:104]
   output logic [119:0]  rsp_tdata,
   output logic          rsp_tlast
);

   logic               take, push, pop, q_valid, q_full;
   stt_pkg::pair_type  wr_pair, head;
   stt_pkg::token_type out_tok;

   assign req_tready = !q_full;
   assign take       = req_tvalid && req_tready;

   stt_front u_front (
      .clock (clock),
      .reset (reset),
      .take  (take),
      .ch    (req_tdata),
      .endm  (req_tuser),
      .push  (push),
      .pair  (wr_pair)
   );

   stt_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .wr_pair   (wr_pair),
      .pop       (pop),
      .not_empty (q_valid),
      .full      (q_full),
      .head      (head)
   );

   stt_back u_back (
      .clock     (clock),
      .reset     (reset),
      .q_valid   (q_valid),
      .head      (head),
      .pop       (pop),
      .out_valid (rsp_tvalid),
      .out_tok   (out_tok),
      .out_last  (rsp_tlast),
      .out_ready (rsp_tready)
   );

   assign rsp_tdata = {out_tok.scol, out_tok.sline, out_tok.len, out_tok.fdig,
                       out_tok.fval, out_tok.ival, out_tok.kind};

`ifndef SYNTH
   // end token always closes its byte's tokens
   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tdata[5:0] == stt_pkg::K_END) |-> rsp_tlast)
      else $error("end token without last");

   // nothing follows the end token
   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tready && rsp_tdata[5:0] == stt_pkg::K_END) |=> !rsp_tvalid)
      else $error("token after end token");

   // queue pop only when data is there
   assert property (@(posedge clock) disable iff (reset) pop |-> q_valid)
      else $error("pop from empty queue");
`endif

endmodule
